FILE: hw/rtl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, constants and tables for the integer to ASCII radix formatter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int CALC_WIDTH  = VALUE_WIDTH + 4;

  typedef enum logic [1:0] {
    OP_SDEC = 2'd0,
    OP_UDEC = 2'd1,
    OP_OCT  = 2'd2,
    OP_HEX  = 2'd3
  } op_t;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_ALPHA = 8'h37;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_X     = 8'h78;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  function automatic int dec_digit_count();
    longint unsigned v;
    int n;
    v = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - VALUE_WIDTH);
    n = 0;
    while (v != 0) begin
      v = v / 10;
      n++;
    end
    return n;
  endfunction

  localparam int DEC_DIGITS = dec_digit_count();
  localparam int OCT_DIGITS = (VALUE_WIDTH + 2) / 3;
  localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
  localparam int MAX_DIGITS = OCT_DIGITS;
  localparam int K_W        = $clog2(MAX_DIGITS);

  typedef logic [CALC_WIDTH-1:0] calc_t;
  typedef logic [K_W-1:0]        kidx_t;
  typedef calc_t                 pow_tab_t [MAX_DIGITS];

  function automatic pow_tab_t build_pow(int shift_bits, bit is_dec);
    calc_t p;
    pow_tab_t t;
    p = calc_t'(1);
    for (int k = 0; k < MAX_DIGITS; k++) begin
      t[k] = p;
      if (is_dec) begin
        p = calc_t'(p * 10);
      end else begin
        p = p << shift_bits;
      end
    end
    return t;
  endfunction

  localparam pow_tab_t DEC_POW = build_pow(0, 1'b1);
  localparam pow_tab_t OCT_POW = build_pow(3, 1'b0);
  localparam pow_tab_t HEX_POW = build_pow(4, 1'b0);

  localparam kidx_t DEC_TOP = kidx_t'(DEC_DIGITS - 1);
  localparam kidx_t OCT_TOP = kidx_t'(OCT_DIGITS - 1);
  localparam kidx_t HEX_TOP = kidx_t'(HEX_DIGITS - 1);

  typedef struct packed {
    logic load;
    logic start;
    logic step;
  } unit_ctl_t;

  typedef struct packed {
    logic last_step;
  } unit_sts_t;

  function automatic logic [7:0] digit_char(logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {4'h0, d};
    end else begin
      c = CHAR_ALPHA + {4'h0, d};
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/itoa_in_if.sv
// ----------------------------------------------------------------------------
// itoa_in_if
// Number channel: value and format opcode with valid/ready.
// ----------------------------------------------------------------------------
interface itoa_in_if;
  import itoa_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;
  logic [1:0]             opcode;

  modport source (output valid, output value, output opcode, input ready);
  modport sink   (input valid, input value, input opcode, output ready);
endinterface

FILE: hw/rtl/itoa_out_if.sv
// ----------------------------------------------------------------------------
// itoa_out_if
// Character channel: one ASCII character and end-of-number flag per transfer.
// ----------------------------------------------------------------------------
interface itoa_out_if;
  import itoa_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] ascii_char;
  logic       last;

  modport source (output valid, output ascii_char, output last, input ready);
  modport sink   (input valid, input ascii_char, input last, output ready);
endinterface

FILE: hw/rtl/integer_to_ascii_radix_formatter.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_formatter
// Formats a number as signed/unsigned decimal, octal or 0x-prefixed hex ASCII.
//
//   channel  dir   payload               transfer
//   number   in    value, opcode         valid & ready
//   chars    out   ascii_char, last      valid & ready
//
// One number at a time; number.ready is high only in idle.
// Each digit position runs: load weight, 4 or 3 (octal) compare-subtract
// steps in the shared unit, then the digit check/output.
// Every position is visited; leading zeros are dropped after the check.
// A stalled chars channel holds the current character. rst returns to idle.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_formatter (
  input logic   clk,
  input logic   rst,
  itoa_in_if.sink    number,
  itoa_out_if.source chars
);
  import itoa_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SIGN  = 8'b0000_0010,
    S_PFX0  = 8'b0000_0100,
    S_PFXX  = 8'b0000_1000,
    S_START = 8'b0001_0000,
    S_STEP  = 8'b0010_0000,
    S_DIGIT = 8'b0100_0000,
    S_SPACE = 8'b1000_0000
  } state_t;

  state_t    state, state_next;
  op_t       op, op_next;
  kidx_t     k, k_next;
  logic      started, started_next;

  unit_ctl_t              ctl;
  unit_sts_t              sts;
  logic [3:0]             digit;
  logic [VALUE_WIDTH-1:0] mag;
  op_t                    in_op;
  logic                   neg;
  logic                   skip;

  assign in_op = op_t'(number.opcode);
  assign neg   = (in_op == OP_SDEC) && number.value[VALUE_WIDTH-1];
  assign mag   = neg ? (~number.value + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : number.value;
  assign skip  = (digit == 4'd0) && !started && (k != '0);

  itoa_digit_unit u_digit (
    .clk   (clk),
    .ctl   (ctl),
    .mag   (mag),
    .op    (op),
    .k     (k),
    .sts   (sts),
    .digit (digit)
  );

  always_comb begin
    state_next       = state;
    op_next          = op;
    k_next           = k;
    started_next     = started;
    ctl              = '0;
    number.ready     = 1'b0;
    chars.valid      = 1'b0;
    chars.ascii_char = CHAR_SPACE;
    chars.last       = 1'b0;

    unique case (state)
      S_IDLE: begin
        number.ready = 1'b1;
        if (number.valid) begin
          ctl.load     = 1'b1;
          op_next      = in_op;
          started_next = 1'b0;
          unique case (in_op)
            OP_OCT:  k_next = OCT_TOP;
            OP_HEX:  k_next = HEX_TOP;
            default: k_next = DEC_TOP;
          endcase
          if (neg) begin
            state_next = S_SIGN;
          end else if (in_op == OP_HEX) begin
            state_next = S_PFX0;
          end else begin
            state_next = S_START;
          end
        end
      end
      S_SIGN: begin
        chars.valid      = 1'b1;
        chars.ascii_char = CHAR_MINUS;
        if (chars.ready) begin
          state_next = S_START;
        end
      end
      S_PFX0: begin
        chars.valid      = 1'b1;
        chars.ascii_char = CHAR_ZERO;
        if (chars.ready) begin
          state_next = S_PFXX;
        end
      end
      S_PFXX: begin
        chars.valid      = 1'b1;
        chars.ascii_char = CHAR_X;
        if (chars.ready) begin
          state_next = S_START;
        end
      end
      S_START: begin
        ctl.start  = 1'b1;
        state_next = S_STEP;
      end
      S_STEP: begin
        ctl.step = 1'b1;
        if (sts.last_step) begin
          state_next = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (skip) begin
          k_next     = k - kidx_t'(1);
          state_next = S_START;
        end else begin
          chars.valid      = 1'b1;
          chars.ascii_char = digit_char(digit);
          if (chars.ready) begin
            started_next = 1'b1;
            if (k == '0) begin
              state_next = S_SPACE;
            end else begin
              k_next     = k - kidx_t'(1);
              state_next = S_START;
            end
          end
        end
      end
      S_SPACE: begin
        chars.valid      = 1'b1;
        chars.ascii_char = CHAR_SPACE;
        chars.last       = 1'b1;
        if (chars.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      started <= 1'b0;
    end else begin
      state   <= state_next;
      started <= started_next;
    end
    op <= op_next;
    k  <= k_next;
  end
endmodule

FILE: hw/rtl/itoa_digit_unit.sv
// ----------------------------------------------------------------------------
// itoa_digit_unit
// Shared compare-subtract unit: extracts one digit, one weight bit per cycle.
// ----------------------------------------------------------------------------
module itoa_digit_unit (
  input  logic                             clk,
  input  itoa_pkg::unit_ctl_t              ctl,
  input  logic [itoa_pkg::VALUE_WIDTH-1:0] mag,
  input  itoa_pkg::op_t                    op,
  input  itoa_pkg::kidx_t                  k,
  output itoa_pkg::unit_sts_t              sts,
  output logic [3:0]                       digit
);
  import itoa_pkg::*;

  calc_t      rem;
  calc_t      pow;
  logic [1:0] j;
  calc_t      wgt;
  logic       fits;

  assign wgt       = pow << j;
  assign fits      = rem >= wgt;
  assign sts.last_step = (j == 2'd0);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem <= calc_t'(mag);
    end else if (ctl.step && fits) begin
      rem <= rem - wgt;
    end

    if (ctl.start) begin
      unique case (op)
        OP_OCT:  pow <= OCT_POW[k];
        OP_HEX:  pow <= HEX_POW[k];
        default: pow <= DEC_POW[k];
      endcase
      j     <= (op == OP_OCT) ? 2'd2 : 2'd3;
      digit <= 4'd0;
    end else if (ctl.step) begin
      digit[j] <= fits;
      j        <= j - 2'd1;
    end
  end
endmodule
